// ===== src/acs_pkg.sv =====
// Shared types, opcodes and command codes for the accumulator processor step block
package acs_pkg;

  // command codes carried by an input word
  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // opcodes
  localparam logic [7:0] OP_NOP   = 8'h00;
  localparam logic [7:0] OP_STA   = 8'h32;
  localparam logic [7:0] OP_LDA   = 8'h3A;
  localparam logic [7:0] OP_LDI   = 8'h3E;
  localparam logic [7:0] OP_TAX   = 8'h6F;
  localparam logic [7:0] OP_HALT  = 8'h76;
  localparam logic [7:0] OP_STX   = 8'h77;
  localparam logic [7:0] OP_TXA   = 8'h7D;
  localparam logic [7:0] OP_LDX   = 8'h7E;
  localparam logic [7:0] OP_ADDX  = 8'h86;
  localparam logic [7:0] OP_SUBX  = 8'h96;
  localparam logic [7:0] OP_ANDX  = 8'hA6;
  localparam logic [7:0] OP_XORX  = 8'hAE;
  localparam logic [7:0] OP_JNZ   = 8'hC2;
  localparam logic [7:0] OP_JMP   = 8'hC3;
  localparam logic [7:0] OP_ADDI  = 8'hC6;
  localparam logic [7:0] OP_INX   = 8'hC9;
  localparam logic [7:0] OP_JZ    = 8'hCA;
  localparam logic [7:0] OP_SUBI  = 8'hD6;
  localparam logic [7:0] OP_ANDI  = 8'hE6;
  localparam logic [7:0] OP_XORI  = 8'hEE;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_OPER,
    ST_DATA,
    ST_WRITE,
    ST_READ,
    ST_OTHER
  } state_t;

  // datapath step selected by the controller
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_CLEAR,
    STEP_ACCEPT,
    STEP_DEC,
    STEP_OPER,
    STEP_DATA,
    STEP_WRITE,
    STEP_READ,
    STEP_OTHER
  } step_t;

  // how many memory steps an opcode needs after its fetch
  typedef enum logic [1:0] {
    KIND_SINGLE,    // done at decode
    KIND_OPER,      // done when the operand byte is in
    KIND_OPER_DATA, // operand, then a data read at the operand address
    KIND_X_DATA     // data read at X
  } op_kind_t;

  typedef struct packed {
    step_t step;
    logic  load_out;
  } ctl_cmd_t;

  typedef struct packed {
    op_kind_t kind_dec;
    op_kind_t kind_cur;
    logic     clear_done;
    logic     out_free;
  } dp_status_t;

  function automatic op_kind_t op_kind(input logic [7:0] op);
    op_kind_t k;
    k = KIND_SINGLE;
    case (op) inside
      OP_LDI, OP_ADDI, OP_SUBI, OP_ANDI, OP_XORI, OP_STA, OP_JMP, OP_JZ, OP_JNZ:
        k = KIND_OPER;
      OP_LDA:
        k = KIND_OPER_DATA;
      OP_LDX, OP_ADDX, OP_SUBX, OP_ANDX, OP_XORX:
        k = KIND_X_DATA;
      default:
        k = KIND_SINGLE;
    endcase
    return k;
  endfunction

endpackage

// ===== src/acs_if.sv =====
// Valid/ready channel interfaces for command words and result words
interface acs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] mem_address;
  logic [7:0] write_data;

  modport source (output valid, output command, output mem_address, output write_data,
                  input ready);
  modport sink (input valid, input command, input mem_address, input write_data,
                output ready);
endinterface

interface acs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] program_counter;
  logic [7:0] accumulator;
  logic [7:0] index_reg;
  logic [7:0] opcode_done;
  logic [7:0] read_data;
  logic       halted;
  logic       bad_opcode;

  modport source (output valid, output program_counter, output accumulator,
                  output index_reg, output opcode_done, output read_data,
                  output halted, output bad_opcode, input ready);
  modport sink (input valid, input program_counter, input accumulator,
                input index_reg, input opcode_done, input read_data,
                input halted, input bad_opcode, output ready);
endinterface

// ===== src/acs_ctrl.sv =====
// Controller state machine sequencing memory steps of each command
module acs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_command,
  output logic                in_ready,
  input  acs_pkg::dp_status_t status,
  output acs_pkg::ctl_cmd_t   cmd
);

  acs_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and step commands
  always_comb begin
    state_nxt    = state_r;
    cmd.step     = acs_pkg::STEP_NONE;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    case (state_r)
      acs_pkg::ST_CLEAR: begin
        cmd.step = acs_pkg::STEP_CLEAR;
        if (status.clear_done) state_nxt = acs_pkg::ST_IDLE;
      end
      acs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step = acs_pkg::STEP_ACCEPT;
          case (in_command)
            acs_pkg::CMD_EXEC:  state_nxt = acs_pkg::ST_DEC;
            acs_pkg::CMD_WRITE: state_nxt = acs_pkg::ST_WRITE;
            acs_pkg::CMD_READ:  state_nxt = acs_pkg::ST_READ;
            default:            state_nxt = acs_pkg::ST_OTHER;
          endcase
        end
      end
      acs_pkg::ST_DEC: begin
        case (status.kind_dec)
          acs_pkg::KIND_SINGLE: begin
            if (status.out_free) begin
              cmd.step     = acs_pkg::STEP_DEC;
              cmd.load_out = 1'b1;
              state_nxt    = acs_pkg::ST_IDLE;
            end
          end
          acs_pkg::KIND_X_DATA: begin
            cmd.step  = acs_pkg::STEP_DEC;
            state_nxt = acs_pkg::ST_DATA;
          end
          default: begin
            cmd.step  = acs_pkg::STEP_DEC;
            state_nxt = acs_pkg::ST_OPER;
          end
        endcase
      end
      acs_pkg::ST_OPER: begin
        if (status.kind_cur == acs_pkg::KIND_OPER_DATA) begin
          cmd.step  = acs_pkg::STEP_OPER;
          state_nxt = acs_pkg::ST_DATA;
        end else if (status.out_free) begin
          cmd.step     = acs_pkg::STEP_OPER;
          cmd.load_out = 1'b1;
          state_nxt    = acs_pkg::ST_IDLE;
        end
      end
      acs_pkg::ST_DATA: begin
        if (status.out_free) begin
          cmd.step     = acs_pkg::STEP_DATA;
          cmd.load_out = 1'b1;
          state_nxt    = acs_pkg::ST_IDLE;
        end
      end
      acs_pkg::ST_WRITE: begin
        if (status.out_free) begin
          cmd.step     = acs_pkg::STEP_WRITE;
          cmd.load_out = 1'b1;
          state_nxt    = acs_pkg::ST_IDLE;
        end
      end
      acs_pkg::ST_READ: begin
        if (status.out_free) begin
          cmd.step     = acs_pkg::STEP_READ;
          cmd.load_out = 1'b1;
          state_nxt    = acs_pkg::ST_IDLE;
        end
      end
      acs_pkg::ST_OTHER: begin
        if (status.out_free) begin
          cmd.step     = acs_pkg::STEP_OTHER;
          cmd.load_out = 1'b1;
          state_nxt    = acs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = acs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/acs_dpath.sv =====
// Datapath: registers, single-port memory, ALU and result register
module acs_dpath #(
  parameter int MEM_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  acs_pkg::ctl_cmd_t   cmd,
  output acs_pkg::dp_status_t status,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_mem_address,
  input  logic [7:0]          in_write_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_program_counter,
  output logic [7:0]          out_accumulator,
  output logic [7:0]          out_index_reg,
  output logic [7:0]          out_opcode_done,
  output logic [7:0]          out_read_data,
  output logic                out_halted,
  output logic                out_bad_opcode
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] clr_cnt_r;

  logic [7:0] pc_r, acc_r, x_r, instr_r;
  logic [7:0] pc_nxt, acc_nxt, x_nxt, instr_nxt;
  logic [7:0] addr_hold_r, wdata_hold_r;

  logic       out_valid_r;
  logic [7:0] out_pc_r, out_acc_r, out_x_r, out_op_r, out_rd_r;
  logic       out_halt_r, out_bad_r;

  logic       rd_en, wr_en;
  logic [7:0] rd_addr, wr_addr, wr_data;
  logic       rd_ok, wr_ok;
  logic [7:0] rdat, pc_inc;
  logic       halt, bad;

  // memory port, out-of-range reads give zero and writes are dropped
  assign rd_ok = {1'b0, rd_addr} < 9'(MEM_DEPTH);
  assign wr_ok = {1'b0, wr_addr} < 9'(MEM_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) mem[wr_addr[AW-1:0]] <= wr_data;
    if (rd_en) rdata_r <= rd_ok ? mem[rd_addr[AW-1:0]] : 8'h00;
  end

  assign pc_inc = pc_r + 8'd1;

  // step behavior
  always_comb begin
    pc_nxt    = pc_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    instr_nxt = instr_r;
    rd_en     = 1'b0;
    rd_addr   = pc_r;
    wr_en     = 1'b0;
    wr_addr   = pc_r;
    wr_data   = acc_r;
    rdat      = 8'h00;
    halt      = 1'b0;
    bad       = 1'b0;
    case (cmd.step)
      acs_pkg::STEP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = 8'(clr_cnt_r);
        wr_data = 8'h00;
      end
      acs_pkg::STEP_ACCEPT: begin
        rd_en   = 1'b1;
        rd_addr = (in_command == acs_pkg::CMD_EXEC) ? pc_r : in_mem_address;
      end
      acs_pkg::STEP_DEC: begin
        instr_nxt = rdata_r;
        pc_nxt    = pc_inc;
        case (rdata_r)
          acs_pkg::OP_NOP: ;
          acs_pkg::OP_TAX: x_nxt = acc_r;
          acs_pkg::OP_TXA: acc_nxt = x_r;
          acs_pkg::OP_INX: x_nxt = x_r + 8'd1;
          acs_pkg::OP_STX: begin
            wr_en   = 1'b1;
            wr_addr = x_r;
          end
          acs_pkg::OP_HALT: begin
            // clear the halt byte and point back at it
            pc_nxt  = pc_r;
            wr_en   = 1'b1;
            wr_addr = pc_r;
            wr_data = 8'h00;
            halt    = 1'b1;
          end
          acs_pkg::OP_LDI, acs_pkg::OP_ADDI, acs_pkg::OP_SUBI, acs_pkg::OP_ANDI,
          acs_pkg::OP_XORI, acs_pkg::OP_LDA, acs_pkg::OP_STA, acs_pkg::OP_JMP,
          acs_pkg::OP_JZ, acs_pkg::OP_JNZ: begin
            rd_en   = 1'b1;
            rd_addr = pc_inc;
          end
          acs_pkg::OP_LDX, acs_pkg::OP_ADDX, acs_pkg::OP_SUBX, acs_pkg::OP_ANDX,
          acs_pkg::OP_XORX: begin
            rd_en   = 1'b1;
            rd_addr = x_r;
          end
          default: bad = 1'b1;
        endcase
      end
      acs_pkg::STEP_OPER: begin
        // operand byte n is in rdata_r
        pc_nxt = pc_inc;
        case (instr_r)
          acs_pkg::OP_LDI:  acc_nxt = rdata_r;
          acs_pkg::OP_ADDI: acc_nxt = acc_r + rdata_r;
          acs_pkg::OP_SUBI: acc_nxt = acc_r - rdata_r;
          acs_pkg::OP_ANDI: acc_nxt = acc_r & rdata_r;
          acs_pkg::OP_XORI: acc_nxt = acc_r ^ rdata_r;
          acs_pkg::OP_LDA: begin
            rd_en   = 1'b1;
            rd_addr = rdata_r;
          end
          acs_pkg::OP_STA: begin
            wr_en   = 1'b1;
            wr_addr = rdata_r;
          end
          acs_pkg::OP_JMP: pc_nxt = rdata_r;
          acs_pkg::OP_JZ:  pc_nxt = (acc_r == 8'h00) ? rdata_r : pc_inc;
          acs_pkg::OP_JNZ: pc_nxt = (acc_r != 8'h00) ? rdata_r : pc_inc;
          default: pc_nxt = pc_r;
        endcase
      end
      acs_pkg::STEP_DATA: begin
        case (instr_r)
          acs_pkg::OP_LDA, acs_pkg::OP_LDX: acc_nxt = rdata_r;
          acs_pkg::OP_ADDX: acc_nxt = acc_r + rdata_r;
          acs_pkg::OP_SUBX: acc_nxt = acc_r - rdata_r;
          acs_pkg::OP_ANDX: acc_nxt = acc_r & rdata_r;
          acs_pkg::OP_XORX: acc_nxt = acc_r ^ rdata_r;
          default: ;
        endcase
      end
      acs_pkg::STEP_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = addr_hold_r;
        wr_data = wdata_hold_r;
      end
      acs_pkg::STEP_READ: rdat = rdata_r;
      acs_pkg::STEP_OTHER: ;
      default: ;
    endcase
  end

  // architectural registers and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= 8'h00;
      acc_r     <= 8'h00;
      x_r       <= 8'h00;
      instr_r   <= 8'h00;
      clr_cnt_r <= '0;
    end else begin
      pc_r    <= pc_nxt;
      acc_r   <= acc_nxt;
      x_r     <= x_nxt;
      instr_r <= instr_nxt;
      if (cmd.step == acs_pkg::STEP_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // captured address and data of the accepted word
  always_ff @(posedge clk) begin
    if (cmd.step == acs_pkg::STEP_ACCEPT) begin
      addr_hold_r  <= in_mem_address;
      wdata_hold_r <= in_write_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pc_r   <= pc_nxt;
      out_acc_r  <= acc_nxt;
      out_x_r    <= x_nxt;
      out_op_r   <= instr_nxt;
      out_rd_r   <= rdat;
      out_halt_r <= halt;
      out_bad_r  <= bad;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_program_counter = out_pc_r;
  assign out_accumulator     = out_acc_r;
  assign out_index_reg       = out_x_r;
  assign out_opcode_done     = out_op_r;
  assign out_read_data       = out_rd_r;
  assign out_halted          = out_halt_r;
  assign out_bad_opcode      = out_bad_r;

  // status toward the controller
  assign status.kind_dec   = acs_pkg::op_kind(rdata_r);
  assign status.kind_cur   = acs_pkg::op_kind(instr_r);
  assign status.clear_done = (clr_cnt_r == AW'(MEM_DEPTH - 1));
  assign status.out_free   = !out_valid_r || out_ready;

endmodule

// ===== src/accumulator_cpu_step_top.sv =====
// Top level of the accumulator processor step block
// Each command word yields one result word. After reset the block clears its
// MEM_DEPTH-byte memory one byte per cycle and accepts no word until done.
// A single-port memory with a registered read sets the steps: write, read and
// unused commands take a step of their own; an execute decodes and ends
// there for register-only ops, NOP, halt, store through X and unknown opcodes,
// adds an operand step for immediate, store direct, jump and branch ops or a
// data step for M(X) ops, and both for the direct load. A new word is accepted
// while a result still waits; the result register stalls completion of the
// next word only if the previous result has not been taken.
module accumulator_cpu_step_top #(
  parameter int MEM_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  acs_in_if.sink    in_ch,
  acs_out_if.source out_ch
);

  acs_pkg::ctl_cmd_t   cmd;
  acs_pkg::dp_status_t status;

  // sequencing
  acs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // registers, memory and result register
  acs_dpath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_command          (in_ch.command),
    .in_mem_address      (in_ch.mem_address),
    .in_write_data       (in_ch.write_data),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_program_counter (out_ch.program_counter),
    .out_accumulator     (out_ch.accumulator),
    .out_index_reg       (out_ch.index_reg),
    .out_opcode_done     (out_ch.opcode_done),
    .out_read_data       (out_ch.read_data),
    .out_halted          (out_ch.halted),
    .out_bad_opcode      (out_ch.bad_opcode)
  );

endmodule

// ===== src/acs_checker.sv =====
// Port-level assertions for the accumulator processor step block
module acs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_program_counter,
  input logic [7:0] out_read_data,
  input logic       out_halted,
  input logic       out_bad_opcode
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_program_counter) &&
                                $stable(out_read_data) && $stable(out_halted))
    else $error("result word changed while stalled");

  // one word at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous one still in work");

  // memory clearing keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input open during memory clear");

  // halt and unknown opcode come only from execute, never with read data
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_halted || out_bad_opcode) |->
      !(out_halted && out_bad_opcode) && (out_read_data == 8'h00))
    else $error("inconsistent result flags");

endmodule

bind accumulator_cpu_step_top acs_checker u_acs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_program_counter (out_ch.program_counter),
  .out_read_data       (out_ch.read_data),
  .out_halted          (out_ch.halted),
  .out_bad_opcode      (out_ch.bad_opcode)
);
